// ===== hdl/integer_field_formatter_defines.svh =====
// Assertion helpers for the formatter.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_DEFINES_SVH

// same-cycle implication
`define IFF_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IFF_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/iff_pkg.sv =====
package iff_pkg;

  // conversion kinds (in_tuser)
  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_LHEX = 3'd2;
  localparam logic [2:0] MODE_UHEX = 3'd3;
  localparam logic [2:0] MODE_PTR  = 3'd4;

  localparam int MODE_W    = 3;
  localparam int VAL_W     = 64;
  localparam int HALF_W    = 32;
  localparam int FW_W      = 6;
  localparam int CHAR_W    = 8;
  localparam int IN_DATA_W = 80;
  localparam int BCD_N     = 10;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_PLAN, ST_LEAD, ST_SIGN,
    ST_PFX0, ST_PFX1, ST_ZERO, ST_DIG, ST_TRAIL
  } state_t;

  // which run the emitted character belongs to
  typedef enum logic [2:0] {
    EM_LEAD, EM_SIGN, EM_PFX0, EM_PFX1, EM_ZRUN, EM_DIGIT, EM_TRAIL
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  plan;
    logic  emit;
    emit_t sel;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic in_mode_ok;
    logic in_dec;
    logic conv_done;
    logic neg;
    logic ptr;
    logic lead_nz;
    logic lead_one;
    logic zero_nz;
    logic zero_one;
    logic trail_nz;
    logic trail_one;
    logic dig_last;
    logic slot_free;
  } sts_t;

endpackage

// ===== hdl/iff_dp.sv =====
module iff_dp #(
  parameter int MAX_PAD = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [iff_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [iff_pkg::MODE_W-1:0]    in_tuser,
  input  iff_pkg::cmd_t                 cmd,
  output iff_pkg::sts_t                 sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [iff_pkg::CHAR_W-1:0]    out_tdata,
  output logic                          out_tlast
);
  import iff_pkg::*;

  localparam logic [FW_W-1:0] PAD_MAX = FW_W'(MAX_PAD);

  function automatic logic [FW_W-1:0] pos6(input logic signed [7:0] a);
    pos6 = a[7] ? '0 : a[FW_W-1:0];
  endfunction

  // input word fields
  logic [VAL_W-1:0]  in_value;
  logic              in_la, in_zp, in_hp;
  logic [FW_W-1:0]   in_fw, in_pr;
  logic [HALF_W-1:0] v32, mag32;
  logic              neg_in;

  assign in_value = in_tdata[63:0];
  assign in_la    = in_tdata[64];
  assign in_zp    = in_tdata[65];
  assign in_hp    = in_tdata[66];
  assign in_fw    = in_tdata[72:67];
  assign in_pr    = in_tdata[78:73];
  assign v32      = in_value[HALF_W-1:0];
  assign neg_in   = (in_tuser == MODE_SDEC) && v32[HALF_W-1];
  assign mag32    = neg_in ? (~v32 + 32'd1) : v32;

  logic [VAL_W-1:0]  dig_r, dig_nxt;     // nibble store: hex digits or BCD
  logic [HALF_W-1:0] bin_r, bin_nxt;     // binary shifted out during dabble
  logic [4:0]        bit_r, bit_nxt;
  logic              neg_r, neg_nxt, ptr_r, ptr_nxt, upper_r, upper_nxt;
  logic              la_r, la_nxt, zp_r, zp_nxt, hp_r, hp_nxt;
  logic [FW_W-1:0]   w_r, w_nxt, pr_r, pr_nxt;
  logic [FW_W-1:0]   lead_r, lead_nxt, zero_r, zero_nxt, trail_r, trail_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;

  // double dabble adjust
  logic [4*BCD_N-1:0] adj;
  always_comb begin
    for (int i = 0; i < BCD_N; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3
                                                 : dig_r[4*i +: 4];
    end
  end

  // digit count: highest nonzero nibble, at least one digit
  logic [3:0] top;
  always_comb begin
    top = '0;
    for (int i = 0; i < 16; i++) begin
      if (dig_r[4*i +: 4] != 4'd0) top = 4'(i);
    end
  end

  // run lengths
  logic signed [7:0] wx, px, nx, sx, sp, zr, body;
  always_comb begin
    wx = signed'({2'b00, w_r});
    px = signed'({2'b00, pr_r});
    nx = signed'({4'b0000, top}) + 8'sd1;
    sx = signed'({7'd0, neg_r});
    zr = '0;
    body = '0;
    if (ptr_r) begin
      sp = wx - nx - 8'sd2;
    end else if (hp_r) begin
      zr   = px - nx;
      body = (zr > 8'sd0) ? px : nx;
      sp   = wx - body - sx;
    end else begin
      sp = wx - nx - sx;
      if (zp_r && !la_r) begin
        zr = sp;
        sp = '0;
      end
    end
  end

  logic [3:0]        nib;
  logic [CHAR_W-1:0] dchar;
  assign nib   = dig_r[{idx_r, 2'b00} +: 4];
  assign dchar = (nib < 4'd10) ? CH_ZERO + {4'b0000, nib}
                               : (upper_r ? CH_UA : CH_LA) + {4'b0000, nib} - 8'd10;

  always_comb begin
    dig_nxt   = dig_r;   bin_nxt  = bin_r;   bit_nxt  = bit_r;
    neg_nxt   = neg_r;   ptr_nxt  = ptr_r;   upper_nxt = upper_r;
    la_nxt    = la_r;    zp_nxt   = zp_r;    hp_nxt   = hp_r;
    w_nxt     = w_r;     pr_nxt   = pr_r;
    lead_nxt  = lead_r;  zero_nxt = zero_r;  trail_nxt = trail_r;
    idx_nxt   = idx_r;
    ochar_nxt = ochar_r; olast_nxt = olast_r;
    ovalid_nxt = cmd.emit | (ovalid_r & ~out_tready);

    if (cmd.load) begin
      neg_nxt   = neg_in;
      ptr_nxt   = (in_tuser == MODE_PTR);
      upper_nxt = (in_tuser == MODE_UHEX);
      la_nxt    = in_la;
      zp_nxt    = in_zp;
      hp_nxt    = in_hp;
      w_nxt     = (in_fw > PAD_MAX) ? PAD_MAX : in_fw;
      pr_nxt    = (in_pr > PAD_MAX) ? PAD_MAX : in_pr;
      bit_nxt   = '0;
      bin_nxt   = mag32;
      if (in_tuser == MODE_PTR) dig_nxt = in_value;
      else if (in_tuser == MODE_LHEX || in_tuser == MODE_UHEX) dig_nxt = {32'd0, v32};
      else dig_nxt = '0;
    end

    if (cmd.step) begin
      dig_nxt = {24'd0, adj[4*BCD_N-2:0], bin_r[HALF_W-1]};
      bin_nxt = {bin_r[HALF_W-2:0], 1'b0};
      bit_nxt = bit_r + 5'd1;
    end

    if (cmd.plan) begin
      idx_nxt   = top;
      zero_nxt  = pos6(zr);
      lead_nxt  = la_r ? '0 : pos6(sp);
      trail_nxt = la_r ? pos6(sp) : '0;
    end

    if (cmd.emit) begin
      olast_nxt = cmd.last;
      case (cmd.sel)
        EM_LEAD: begin
          ochar_nxt = CH_SPACE;
          lead_nxt  = lead_r - 6'd1;
        end
        EM_SIGN:  ochar_nxt = CH_MINUS;
        EM_PFX0:  ochar_nxt = CH_ZERO;
        EM_PFX1:  ochar_nxt = CH_X;
        EM_ZRUN: begin
          ochar_nxt = CH_ZERO;
          zero_nxt  = zero_r - 6'd1;
        end
        EM_DIGIT: begin
          ochar_nxt = dchar;
          idx_nxt   = idx_r - 4'd1;
        end
        EM_TRAIL: begin
          ochar_nxt = CH_SPACE;
          trail_nxt = trail_r - 6'd1;
        end
        default:  ochar_nxt = CH_SPACE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;   bin_r   <= bin_nxt;   bit_r   <= bit_nxt;
    neg_r   <= neg_nxt;   ptr_r   <= ptr_nxt;   upper_r <= upper_nxt;
    la_r    <= la_nxt;    zp_r    <= zp_nxt;    hp_r    <= hp_nxt;
    w_r     <= w_nxt;     pr_r    <= pr_nxt;
    lead_r  <= lead_nxt;  zero_r  <= zero_nxt;  trail_r <= trail_nxt;
    idx_r   <= idx_nxt;
    ochar_r <= ochar_nxt; olast_r <= olast_nxt;
  end

  always_comb begin
    sts.in_mode_ok = (in_tuser <= MODE_PTR);
    sts.in_dec     = (in_tuser == MODE_SDEC) || (in_tuser == MODE_UDEC);
    sts.conv_done  = (bit_r == 5'd31);
    sts.neg        = neg_r;
    sts.ptr        = ptr_r;
    sts.lead_nz    = (lead_r != '0);
    sts.lead_one   = (lead_r == 6'd1);
    sts.zero_nz    = (zero_r != '0);
    sts.zero_one   = (zero_r == 6'd1);
    sts.trail_nz   = (trail_r != '0);
    sts.trail_one  = (trail_r == 6'd1);
    sts.dig_last   = (idx_r == 4'd0);
    sts.slot_free  = ~ovalid_r | out_tready;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule

// ===== hdl/iff_ctrl.sv =====
`include "integer_field_formatter_defines.svh"

module iff_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  iff_pkg::sts_t sts,
  output iff_pkg::cmd_t cmd
);
  import iff_pkg::*;

  state_t state_r, state_nxt;
  state_t after_lead, after_sign;

  assign after_sign = sts.zero_nz ? ST_ZERO : ST_DIG;
  assign after_lead = sts.neg ? ST_SIGN : (sts.ptr ? ST_PFX0 : after_sign);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '{load: 1'b0, step: 1'b0, plan: 1'b0, emit: 1'b0,
                  sel: EM_LEAD, last: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_mode_ok) state_nxt = sts.in_dec ? ST_CONV : ST_PLAN;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.conv_done) state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = ST_LEAD;
      end
      ST_LEAD: begin
        if (!sts.lead_nz) begin
          state_nxt = after_lead;
        end else if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_LEAD;
          if (sts.lead_one) state_nxt = after_lead;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_SIGN;
          state_nxt = after_sign;
        end
      end
      ST_PFX0: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_PFX0;
          state_nxt = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_PFX1;
          state_nxt = ST_DIG;
        end
      end
      ST_ZERO: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_ZRUN;
          if (sts.zero_one) state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_DIGIT;
          cmd.last = sts.dig_last & ~sts.trail_nz;
          if (sts.dig_last) state_nxt = sts.trail_nz ? ST_TRAIL : ST_IDLE;
        end
      end
      ST_TRAIL: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_TRAIL;
          cmd.last = sts.trail_one;
          if (sts.trail_one) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `IFF_AST_IMP(a_emit_slot, cmd.emit, sts.slot_free, "emit into occupied output slot")
  `IFF_AST_IMP(a_emit_busy, cmd.emit, !in_tready, "emit while taking a new word")
  `IFF_AST_NXT(a_last_idle, cmd.emit && cmd.last, state_r == ST_IDLE, "no idle after last")
  `IFF_AST_NXT(a_conv_plan, state_r == ST_CONV && sts.conv_done, state_r == ST_PLAN,
    "conversion did not end in plan")

endmodule

// ===== hdl/integer_field_formatter.sv =====
// Integer field formatter: one request word in, its text out one character per word.
// Decimal modes first convert the value to BCD by shift-and-add-3; hex and pointer do not.
// A new request is taken only once the last character of the previous field has been issued;
// output stalls hold the sequencer in place.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
module integer_field_formatter #(
  parameter int MAX_PAD = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // value[63:0], left_align[64], zero_pad[65], has_precision[66],
  // field_width[72:67], precision[78:73], zero[79]
  input  logic [iff_pkg::IN_DATA_W-1:0] in_tdata,
  // mode[2:0]
  input  logic [iff_pkg::MODE_W-1:0]    in_tuser,
  // character channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_char[7:0]
  output logic [iff_pkg::CHAR_W-1:0]    out_tdata,
  output logic                          out_tlast
);
  import iff_pkg::*;

  // Controller walks the runs of a field in order:
  // lead spaces, sign, "0x", leading zeros, digits, trailing spaces.
  // Datapath holds the digit store, run counters and the output register.
  cmd_t cmd;
  sts_t sts;

  iff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iff_dp #(
    .MAX_PAD (MAX_PAD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Formatter bench: directed corner requests, then ~500 random ones.
// Every accepted request is expanded into its expected characters at the
// moment of acceptance; the character monitor pops them in order.
module tb_top;
  import iff_pkg::*;

  localparam int PAD_LIMIT = 48;
  localparam int RAND_REQS = 500;
  // how long to wait after the last expected character for a stray one:
  // long enough to cover a decimal conversion before its first character
  localparam int DRAIN_CYCLES = 64;

  // one conversion request as it travels on the request channel
  typedef struct {
    logic [2:0]  mode;
    logic [63:0] value;
    bit          left_align;
    bit          zero_pad;
    bit          has_precision;
    logic [5:0]  field_width;
    logic [5:0]  precision;
    bit          wait_idle;  // hold this word back until the text queue is empty
  } fmt_req_t;

  // one expected character word
  typedef struct {
    logic [7:0] ch;
    bit         last;
  } glyph_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // value[63:0], left_align[64], zero_pad[65], has_precision[66],
  // field_width[72:67], precision[78:73], zero[79]
  logic [IN_DATA_W-1:0] in_tdata = '0;
  // mode[2:0]
  logic [MODE_W-1:0]    in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // out_char[7:0]
  logic [CHAR_W-1:0]    out_tdata;
  logic                 out_tlast;

  fmt_req_t pending_reqs[$];
  glyph_t   expected_text[$];
  fmt_req_t req_on_bus;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int reqs_sent = 0;
  int silent_reqs = 0;
  int chars_checked = 0;
  int mismatches = 0;
  int kind_seen[8] = '{default: 0};

  integer_field_formatter #(.MAX_PAD(PAD_LIMIT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: appends the text a request produces to expected_text.
  // ---------------------------------------------------------------------
  function automatic void emit_run(input logic [7:0] ch, input int n);
    glyph_t g;
    g.ch = ch;
    g.last = 1'b0;
    for (int i = 0; i < n; i++) expected_text.push_back(g);
  endfunction

  function automatic void format_field(input fmt_req_t r);
    logic [31:0] low_word;
    logic [63:0] mag;
    logic [63:0] d;
    logic [7:0]  alpha;
    logic [7:0]  digits[$];
    glyph_t      g;
    int          base;
    int          w;
    int          pr;
    int          nd;
    int          space;
    int          zero_run;
    bit          neg;

    // kinds above pointer print nothing at all
    if (r.mode > MODE_PTR) return;

    w  = (r.field_width > PAD_LIMIT) ? PAD_LIMIT : int'(r.field_width);
    pr = (r.precision > PAD_LIMIT) ? PAD_LIMIT : int'(r.precision);
    low_word = r.value[31:0];
    base = 16;
    alpha = CH_LA;
    neg = 1'b0;
    mag = {32'd0, low_word};

    case (r.mode)
      MODE_SDEC: begin
        base = 10;
        // two's complement magnitude; 0x80000000 maps onto itself (10 digits)
        if (low_word[31]) begin
          neg = 1'b1;
          mag = {32'd0, ~low_word + 32'd1};
        end
      end
      MODE_UDEC: base = 10;
      MODE_UHEX: alpha = CH_UA;
      MODE_PTR:  mag = r.value;  // pointer keeps all 64 bits
      default: ;
    endcase

    // most significant digit ends up first; zero still yields one digit
    do begin
      d = mag % 64'(base);
      digits.push_front((d < 10) ? CH_ZERO + 8'(d) : alpha + 8'(d - 10));
      mag = mag / 64'(base);
    end while (mag != 0);
    nd = digits.size();

    if (r.mode == MODE_PTR) begin
      // spaces only; precision and zero_pad have no effect
      space = w - (nd + 2);
      if (!r.left_align) emit_run(CH_SPACE, space);
      emit_run(CH_ZERO, 1);
      emit_run(CH_X, 1);
      foreach (digits[i]) emit_run(digits[i], 1);
      if (r.left_align) emit_run(CH_SPACE, space);
    end else if (r.has_precision) begin
      // precision wins over zero_pad; the sign still counts in the width
      zero_run = pr - nd;
      space = w - ((zero_run > 0) ? pr : nd) - int'(neg);
      if (!r.left_align) emit_run(CH_SPACE, space);
      if (neg) emit_run(CH_MINUS, 1);
      emit_run(CH_ZERO, zero_run);
      foreach (digits[i]) emit_run(digits[i], 1);
      if (r.left_align) emit_run(CH_SPACE, space);
    end else begin
      space = w - nd - int'(neg);
      if (r.zero_pad && !r.left_align) begin
        // zeros go between the sign and the digits
        if (neg) emit_run(CH_MINUS, 1);
        emit_run(CH_ZERO, space);
        foreach (digits[i]) emit_run(digits[i], 1);
      end else begin
        // left_align beats zero_pad
        if (!r.left_align) emit_run(CH_SPACE, space);
        if (neg) emit_run(CH_MINUS, 1);
        foreach (digits[i]) emit_run(digits[i], 1);
        if (r.left_align) emit_run(CH_SPACE, space);
      end
    end

    g = expected_text.pop_back();
    g.last = 1'b1;
    expected_text.push_back(g);
  endfunction

  function automatic fmt_req_t make_req(input logic [2:0] mode, input logic [63:0] value,
                                        input bit la, input bit zp, input bit hp,
                                        input int w, input int pr);
    fmt_req_t r;
    r.mode = mode;
    r.value = value;
    r.left_align = la;
    r.zero_pad = zp;
    r.has_precision = hp;
    r.field_width = 6'(w);
    r.precision = 6'(pr);
    r.wait_idle = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps.
  // The request is predicted on the edge it is accepted.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        format_field(req_on_bus);
        reqs_sent++;
        kind_seen[req_on_bus.mode]++;
        if (req_on_bus.mode > MODE_PTR) silent_reqs++;
        if (burst_left > 0) burst_left--;
      end
      // bus slot is free for a new word after this edge
      if (!in_tvalid || in_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_reqs[0].wait_idle && expected_text.size() != 0) begin
          in_tvalid <= 1'b0;  // pause until all text so far has come out
        end else begin
          req_on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= req_on_bus.mode;
          in_tdata <= {1'b0, req_on_bus.precision, req_on_bus.field_width,
                       req_on_bus.has_precision, req_on_bus.zero_pad,
                       req_on_bus.left_align, req_on_bus.value};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Character monitor. Ready follows a stall mode that is redrawn at
  // random: always ready, mostly ready, mostly stalled, or periodic.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          mismatches++;
          $error("unexpected character word: out_char %h, last %b", out_tdata, out_tlast);
        end else begin
          if (out_tdata !== expected_text[0].ch) begin
            mismatches++;
            $error("out_char mismatch: expected %h, got %h", expected_text[0].ch, out_tdata);
          end
          if (out_tlast !== expected_text[0].last) begin
            mismatches++;
            $error("last mismatch: expected %b, got %b", expected_text[0].last, out_tlast);
          end
          void'(expected_text.pop_front());
        end
      end
      stall_phase++;
      if (stall_phase % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 9) < 3);
        default: out_tready <= ((stall_phase % 7) > 2);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    fmt_req_t r;
    logic [63:0] v;

    // zero value, with and without precision 0
    pending_reqs.push_back(make_req(MODE_SDEC, 64'd0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_SDEC, 64'd0, 0, 0, 1, 0, 0));
    pending_reqs.push_back(make_req(MODE_LHEX, 64'd0, 1, 0, 1, 4, 0));
    // most negative value: zero padding and precision
    pending_reqs.push_back(make_req(MODE_SDEC, 64'h8000_0000, 0, 1, 0, 14, 0));
    pending_reqs.push_back(make_req(MODE_SDEC, 64'h8000_0000, 0, 0, 1, 16, 12));
    pending_reqs.push_back(make_req(MODE_SDEC, 64'h8000_0000, 1, 0, 0, 13, 0));
    // sign counted in width, left aligned
    pending_reqs.push_back(make_req(MODE_SDEC, 64'hFFFF_FFFF, 1, 0, 0, 5, 0));
    pending_reqs.push_back(make_req(MODE_SDEC, 64'h7FFF_FFFF, 0, 0, 0, 3, 0));
    // upper value bits must be ignored outside pointer
    pending_reqs.push_back(make_req(MODE_SDEC, 64'hFFFF_FFFF_0000_002A, 0, 1, 0, 6, 0));
    pending_reqs.push_back(make_req(MODE_UDEC, 64'hFFFF_FFFF, 0, 1, 0, 20, 0));
    pending_reqs.push_back(make_req(MODE_UDEC, 64'hA5A5_0000_0000_0000, 0, 0, 1, 0, 0));
    pending_reqs.push_back(make_req(MODE_LHEX, 64'hDEAD_BEEF, 0, 1, 0, 10, 0));
    pending_reqs.push_back(make_req(MODE_UHEX, 64'hABCD_EF01, 1, 0, 1, 14, 10));
    // precision shorter than the digits
    pending_reqs.push_back(make_req(MODE_UHEX, 64'hFFFF_FFFF, 0, 0, 1, 12, 3));
    // both left_align and zero_pad without precision
    pending_reqs.push_back(make_req(MODE_SDEC, 64'hFFFF_FF85, 1, 1, 0, 9, 0));
    // precision overrides zero_pad
    pending_reqs.push_back(make_req(MODE_SDEC, 64'hFFFF_FF85, 0, 1, 1, 10, 5));
    // pointer: zero, all ones, flags that it must ignore
    pending_reqs.push_back(make_req(MODE_PTR, 64'd0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(MODE_PTR, '1, 1, 1, 1, 63, 63));
    pending_reqs.push_back(make_req(MODE_PTR, 64'h0000_7FFE_1234_5678, 0, 1, 1, 20, 30));
    // saturation of width and precision
    pending_reqs.push_back(make_req(MODE_SDEC, 64'hFFFF_FFFF, 0, 0, 1, 63, 63));
    pending_reqs.push_back(make_req(MODE_UDEC, 64'd7, 0, 1, 0, 63, 0));
    pending_reqs.push_back(make_req(MODE_LHEX, 64'h1, 1, 0, 0, 48, 0));
    // kinds that print nothing
    pending_reqs.push_back(make_req(3'd5, 64'h1234, 0, 0, 0, 10, 0));
    pending_reqs.push_back(make_req(3'd6, '1, 1, 1, 1, 63, 63));
    pending_reqs.push_back(make_req(3'd7, 64'd0, 0, 1, 0, 1, 1));

    for (int n = 0; n < RAND_REQS; n++) begin
      case ($urandom_range(0, 5))
        0:       v = 64'($urandom_range(0, 20));
        1:       v = {$urandom, $urandom};
        2: begin
          case ($urandom_range(0, 2))
            0:       v = {$urandom, 32'h8000_0000};
            1:       v = {$urandom, 32'h7FFF_FFFF};
            default: v = {$urandom, 32'hFFFF_FFFF};
          endcase
        end
        3:       v = 64'd1 << $urandom_range(0, 63);
        default: v = {$urandom, 32'($urandom_range(0, 99999))};
      endcase
      r = make_req(($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4)),
                   v, 1'($urandom), 1'($urandom), 1'($urandom),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, 16),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, 12));
      // idle the block fully once after the directed set and once mid-run
      r.wait_idle = (n == 0) || (n == RAND_REQS / 2);
      pending_reqs.push_back(r);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the driver's updates have settled
    while (pending_reqs.size() != 0 || in_tvalid || expected_text.size() != 0)
      @(negedge clk);
    // let a stray character show up if the block makes one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d of a kind that prints nothing), %0d characters checked",
             reqs_sent, silent_reqs, chars_checked);
    $display("per kind sdec/udec/lhex/uhex/ptr: %0d/%0d/%0d/%0d/%0d, mismatches: %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
